>>> sv/scpr_pkg.sv
// ============================================================================
// Serial command PWM ramp package
// Shared constants for the serial command PWM ramp block: frame sizing,
// command strings, ramp limits and the divide-by-100 reciprocal.
// ============================================================================
`default_nettype none

package scpr_pkg;

    // Frame buffer depth and the widths derived from it.
    localparam int FRAME_DEPTH = 8;
    localparam int POS_W       = $clog2(FRAME_DEPTH + 1);
    localparam int IDX_W       = $clog2(FRAME_DEPTH);

    // Field widths.
    localparam int PERIOD_W  = 16;
    localparam int DUTY_W    = 7;
    localparam int PRODUCT_W = PERIOD_W + DUTY_W;

    // Item kinds.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Characters and command heads (the closing '$' is the current byte).
    localparam logic [7:0]  CHAR_DOLLAR = 8'h24;
    localparam logic [7:0]  CHAR_ZERO   = 8'h30;
    localparam logic [7:0]  CHAR_NINE   = 8'h39;
    localparam logic [55:0] HEAD_MANUAL = "$manual";
    localparam logic [39:0] HEAD_AUTO   = "$auto";
    localparam logic [31:0] HEAD_PWM    = "$PWM";

    // Frame position at which each command's closing '$' arrives.
    localparam logic [POS_W-1:0] CLOSE_MANUAL = POS_W'(7);
    localparam logic [POS_W-1:0] CLOSE_AUTO   = POS_W'(5);
    localparam logic [POS_W-1:0] CLOSE_PWM    = POS_W'(6);
    localparam logic [POS_W-1:0] CLOSE_MIN    = POS_W'(2);

    // Ramp limits and reset period.
    localparam logic [DUTY_W-1:0]   DUTY_MAX     = DUTY_W'(99);
    localparam logic [DUTY_W-1:0]   DUTY_TOP     = DUTY_W'(98);
    localparam logic [DUTY_W-1:0]   DUTY_TEN     = DUTY_W'(10);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(99);

    // x / 100 == (x >> 2) / 25; the latter by reciprocal, exact for x < 2**23.
    localparam int          DIV25_SHIFT = 26;
    localparam logic [21:0] DIV25_RECIP = 22'd2684355;

endpackage : scpr_pkg

`default_nettype wire

>>> sv/scpr_in_if.sv
// ============================================================================
// Serial command PWM ramp input channel
// Valid/ready channel carrying one input word: item kind and received byte.
// ============================================================================
`default_nettype none

interface scpr_in_if;

    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);

endinterface : scpr_in_if

`default_nettype wire

>>> sv/scpr_out_if.sv
// ============================================================================
// Serial command PWM ramp result channel
// Valid/ready channel carrying one result word: compare value, duty and mode.
// ============================================================================
`default_nettype none

interface scpr_out_if;

    logic        valid;
    logic        ready;
    logic [15:0] compare_value;
    logic [6:0]  duty_percent;
    logic        manual_active;

    modport source (output valid, output compare_value, output duty_percent,
                    output manual_active, input ready);
    modport sink   (input valid, input compare_value, input duty_percent,
                    input manual_active, output ready);

endinterface : scpr_out_if

`default_nettype wire

>>> sv/serial_command_pwm_ramp_core.sv
// ============================================================================
// Serial command PWM ramp core
// Gathers '$'-delimited serial command frames, runs a triangle duty ramp on
// timer ticks and reports the PWM compare value for every input word.
// ============================================================================
// Usage:
// Words arrive on the item channel: cmd low carries a received serial byte,
// cmd high a timer tick. Every accepted word yields exactly one result word
// on the result channel, in order, holding period*duty/100, the duty and the
// mode. The period register is written through period_we/period_wdata and
// resets to 99; the user must write it only while the block is idle, which
// the block itself does not enforce. The accepting edge registers the frame
// and ramp update, the multiply stage then registers period*duty and the
// output stage the reciprocal divide by 100, which the result word holds.
// Throughput is one word per cycle while the result channel is not stalled.
// The three stages are elastic: each loads whenever it is empty or its
// contents move on, so words keep being accepted while a result waits, until
// all three stages are full. A stalled receiver holds the result steady.
// Reset clears the frame state, selects automatic mode with zero duty and an
// upward ramp, and empties the pipeline.
// ============================================================================
`default_nettype none

module serial_command_pwm_ramp_core
    import scpr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    scpr_in_if.sink                  item,
    scpr_out_if.source               result,
    input  wire logic                period_we,
    input  wire logic [PERIOD_W-1:0] period_wdata
);

    // Configuration and control state.
    logic [PERIOD_W-1:0] period_reg;
    logic [POS_W-1:0]    pos_reg,      pos_next;
    logic                in_frame_reg, in_frame_next;
    logic                manual_reg,   manual_next;
    logic [DUTY_W-1:0]   duty_reg,     duty_next;
    logic                ramp_up_reg,  ramp_up_next;
    logic [7:0]          frame_chars [FRAME_DEPTH];

    // Pipeline stages.
    logic                 s1_valid_reg;
    logic [DUTY_W-1:0]    s1_duty_reg;
    logic                 s1_manual_reg;
    logic                 s2_valid_reg;
    logic [PRODUCT_W-1:0] s2_product_reg;
    logic [DUTY_W-1:0]    s2_duty_reg;
    logic                 s2_manual_reg;
    logic                 out_valid_reg;
    logic [PERIOD_W-1:0]  out_compare_reg;
    logic [DUTY_W-1:0]    out_duty_reg;
    logic                 out_manual_reg;

    logic accept;
    logic out_free;
    logic s2_free;
    logic s1_free;

    logic                 close_now;
    logic                 pwm_digits_ok;
    logic [3:0]           tens;
    logic [3:0]           units;
    logic [DUTY_W-1:0]    pwm_duty;
    logic [DUTY_W-1:0]    ramp_duty;
    logic [42:0]          quotient_wide;

    // Elastic handshake: a stage loads when empty or when it empties itself.
    assign out_free   = !out_valid_reg || result.ready;
    assign s2_free    = !s2_valid_reg || out_free;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign item.ready = s1_free;
    assign accept     = item.valid && s1_free;

    // Period register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (period_we)
        begin
            period_reg <= period_wdata;
        end
    end

    // Duty digits of a "$PWMdd$" frame.
    always_comb
    begin
        pwm_digits_ok = (frame_chars[4] inside {[CHAR_ZERO:CHAR_NINE]})
                     && (frame_chars[5] inside {[CHAR_ZERO:CHAR_NINE]});
        tens     = 4'(frame_chars[4] - CHAR_ZERO);
        units    = 4'(frame_chars[5] - CHAR_ZERO);
        pwm_duty = DUTY_W'(tens) * DUTY_TEN + DUTY_W'(units);
    end

    // Frame gathering, command decoding and the triangle ramp.
    always_comb
    begin
        pos_next      = pos_reg;
        in_frame_next = in_frame_reg;
        manual_next   = manual_reg;
        duty_next     = duty_reg;
        ramp_up_next  = ramp_up_reg;
        ramp_duty     = duty_reg;
        close_now     = in_frame_reg && (item.rx_byte == CHAR_DOLLAR)
                     && (pos_reg >= CLOSE_MIN);

        if (item.cmd == CMD_BYTE)
        begin
            if (!in_frame_reg)
            begin
                if (item.rx_byte == CHAR_DOLLAR)
                begin
                    in_frame_next = 1'b1;
                    pos_next      = POS_W'(1);
                end
            end
            else if (close_now)
            begin
                in_frame_next = 1'b0;
                pos_next      = '0;
                if (pos_reg == CLOSE_MANUAL
                    && {frame_chars[0], frame_chars[1], frame_chars[2], frame_chars[3],
                        frame_chars[4], frame_chars[5], frame_chars[6]} == HEAD_MANUAL)
                begin
                    manual_next = 1'b1;
                end
                if (pos_reg == CLOSE_AUTO
                    && {frame_chars[0], frame_chars[1], frame_chars[2], frame_chars[3],
                        frame_chars[4]} == HEAD_AUTO)
                begin
                    manual_next = 1'b0;
                end
                if (manual_reg && pos_reg == CLOSE_PWM && pwm_digits_ok
                    && {frame_chars[0], frame_chars[1], frame_chars[2],
                        frame_chars[3]} == HEAD_PWM)
                begin
                    duty_next = pwm_duty;
                end
            end
            else if (pos_reg < POS_W'(FRAME_DEPTH))
            begin
                // Past the buffer every position behaves alike, so it saturates.
                pos_next = pos_reg + POS_W'(1);
            end
        end
        else if (!manual_reg)
        begin
            if (ramp_up_reg)
            begin
                if (duty_reg < DUTY_MAX)
                begin
                    ramp_duty = duty_reg + DUTY_W'(1);
                end
            end
            else if (duty_reg != '0)
            begin
                ramp_duty = duty_reg - DUTY_W'(1);
            end
            duty_next = ramp_duty;
            if (ramp_duty > DUTY_TOP)
            begin
                ramp_up_next = 1'b0;
            end
            if (ramp_duty == '0)
            begin
                ramp_up_next = 1'b1;
            end
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            in_frame_reg <= 1'b0;
            manual_reg   <= 1'b0;
            duty_reg     <= '0;
            ramp_up_reg  <= 1'b1;
        end
        else if (accept)
        begin
            pos_reg      <= pos_next;
            in_frame_reg <= in_frame_next;
            manual_reg   <= manual_next;
            duty_reg     <= duty_next;
            ramp_up_reg  <= ramp_up_next;
        end
    end

    // Frame buffer; only entries written by the current frame are ever read.
    always_ff @(posedge clk)
    begin
        if (accept && item.cmd == CMD_BYTE)
        begin
            if (!in_frame_reg)
            begin
                if (item.rx_byte == CHAR_DOLLAR)
                begin
                    frame_chars[0] <= item.rx_byte;
                end
            end
            else if (pos_reg < POS_W'(FRAME_DEPTH))
            begin
                frame_chars[pos_reg[IDX_W-1:0]] <= item.rx_byte;
            end
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Reciprocal divide by 100 on the registered product.
    assign quotient_wide = 43'(s2_product_reg[PRODUCT_W-1:2]) * 43'(DIV25_RECIP);

    // Pipeline payload: state snapshot, period product, compare value.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_duty_reg   <= duty_next;
            s1_manual_reg <= manual_next;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_product_reg <= PRODUCT_W'(period_reg) * PRODUCT_W'(s1_duty_reg);
            s2_duty_reg    <= s1_duty_reg;
            s2_manual_reg  <= s1_manual_reg;
        end
        if (out_free && s2_valid_reg)
        begin
            out_compare_reg <= quotient_wide[DIV25_SHIFT+PERIOD_W-1:DIV25_SHIFT];
            out_duty_reg    <= s2_duty_reg;
            out_manual_reg  <= s2_manual_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.compare_value = out_compare_reg;
    assign result.duty_percent  = out_duty_reg;
    assign result.manual_active = out_manual_reg;

    // The ramp and duty commands never leave the 0 to 99 range.
    assert property (@(posedge clk) disable iff (!rst_n)
        duty_reg <= DUTY_MAX)
        else $error("duty left the 0 to 99 range");

    // A tick in manual mode leaves the duty alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.cmd == CMD_TICK && manual_reg) |=> $stable(duty_reg))
        else $error("manual tick changed the duty");

    // Outside a frame the position is held at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (pos_reg == '0))
        else $error("frame position set outside a frame");

    // The frame position saturates at the buffer depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(FRAME_DEPTH))
        else $error("frame position beyond saturation");

    // A scaled duty below 100 percent cannot exceed the period.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_compare_reg <= period_reg))
        else $error("compare value above period");

endmodule : serial_command_pwm_ramp_core

`default_nettype wire
